@@ rtl/core/slip_frame_receiver_crc16_macros.svh @@
// Assertion macros for the SLIP frame receiver.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef SLIP_FRAME_RECEIVER_CRC16_MACROS_SVH
`define SLIP_FRAME_RECEIVER_CRC16_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SFR_ASSERT_IMP(lbl, ante, cons, msg)
`define SFR_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/core/sfr_pkg.sv @@
`default_nettype none
package sfr_pkg;

  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  localparam logic [2:0] MIN_RAW = 3'd4;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_UNFINISHED = 3'd1;
  localparam logic [2:0] ST_INVALID    = 3'd2;
  localparam logic [2:0] ST_SHORT      = 3'd3;
  localparam logic [2:0] ST_CRC        = 3'd4;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // Token passed from the decoder to the frame checker.
  typedef enum logic [1:0] {
    TOK_DATA  = 2'd0,
    TOK_CLOSE = 2'd1,
    TOK_ABORT = 2'd2
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [7:0] data;
    logic [2:0] err;
  } tok_t;

  // One byte of CRC-16/CCITT-FALSE, MSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/slip_frame_receiver_crc16.sv @@
`default_nettype none
`include "slip_frame_receiver_crc16_macros.svh"
// SLIP frame receiver with CRC-16/CCITT-FALSE check. Feed one raw serial
// byte per word on rx_byte; the block takes a word every cycle as long as
// its two-entry token queue has room, and delivers at most one result word
// per input word. The decoder's token is registered in the queue, and the
// checker then registers its result in the output register. Bytes
// are dropped until an opening 0xC0. Inside a frame the decoder undoes the
// escapes (DB DC -> C0, DB DD -> DB, anything else after DB is an invalid
// escape that stops decoding for the rest of the frame). The first decoded
// byte is the channel and shows on every result of the frame. Payload bytes
// come out two decoded bytes late, so the trailing big-endian CRC is never
// emitted, with kind 0 and last 0; they arrive before the frame is checked,
// so hold them until the end word says whether to trust them. The end word
// (kind 1, last 1, data_byte 0) carries status: 0 ok, 1 unfinished escape,
// 2 invalid escape, 3 too short, 4 CRC mismatch. A closing 0xC0 after fewer
// than four raw bytes gives no result and opens the next frame. While
// results are taken the sustained rate is one word per cycle, with the CRC
// advancing one byte per cycle in the checker; the queue lets the decoder
// accept while a result waits, until full. No clearing pass follows reset.
module slip_frame_receiver_crc16 import sfr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            kind,
  output logic [7:0]      data_byte,
  output logic [7:0]      channel,
  output logic [2:0]      status,
  output logic            last
);

  logic acc;
  logic push;
  tok_t push_tok;
  tok_t head;
  logic q_empty;
  logic q_full;
  logic pop;
  logic end_word_ok;

  // Take a word whenever the queue can absorb the token it may produce.
  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  // Decoder: hunt, unescape, count raw bytes, classify.
  sfr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .acc     (acc),
    .rx_byte (rx_byte),
    .push    (push),
    .tok     (push_tok)
  );

  // Decouple decoder from checker so each side can stall on its own.
  sfr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_tok (push_tok),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Checker: delay line, CRC, status, output register.
  sfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok       (head),
    .tok_valid (!q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .data_byte (data_byte),
    .channel   (channel),
    .status    (status),
    .last      (last)
  );

  // An end word has last set, no data and one of the defined status codes.
  assign end_word_ok = last && (data_byte == 8'h00) && (status <= ST_CRC);

  `SFR_ASSERT_IMP(a_queue_sane, 1'b1, !(q_full && q_empty), "queue both full and empty")
  `SFR_ASSERT_IMP(a_end_word, out_valid && kind, end_word_ok, "bad end word")
  `SFR_ASSERT_IMP(a_payload_word, out_valid && !kind, (!last && status == ST_OK), "bad payload word")
  `SFR_ASSERT_NXT(a_push_lands, push && q_empty, !q_empty, "token lost at queue")

endmodule
`default_nettype wire

@@ rtl/core/sfr_front.sv @@
`default_nettype none
module sfr_front import sfr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       acc,
  input  wire logic [7:0] rx_byte,
  output logic            push,
  output tok_t            tok
);

  logic       in_frame, in_frame_next;
  logic       esc, esc_next;
  logic       bad, bad_next;
  logic [2:0] raw_count, raw_count_next;

  always_comb begin
    in_frame_next  = in_frame;
    esc_next       = esc;
    bad_next       = bad;
    raw_count_next = raw_count;
    push           = 1'b0;
    tok.kind       = TOK_DATA;
    tok.data       = rx_byte;
    tok.err        = ST_OK;
    if (acc) begin
      if (!in_frame) begin
        // hunt: drop everything until an opening delimiter
        if (rx_byte == SLIP_END) begin
          in_frame_next  = 1'b1;
          esc_next       = 1'b0;
          bad_next       = 1'b0;
          raw_count_next = '0;
        end
      end else if (rx_byte == SLIP_END) begin
        esc_next       = 1'b0;
        bad_next       = 1'b0;
        raw_count_next = '0;
        push           = 1'b1;
        if (raw_count < MIN_RAW) begin
          tok.kind = TOK_ABORT;
        end else begin
          tok.kind      = TOK_CLOSE;
          tok.err       = bad ? ST_INVALID : (esc ? ST_UNFINISHED : ST_OK);
          in_frame_next = 1'b0;
        end
      end else begin
        if (raw_count < MIN_RAW) begin
          raw_count_next = raw_count + 3'd1;
        end
        if (!bad) begin
          if (esc) begin
            esc_next = 1'b0;
            if (rx_byte == SLIP_ESC_END) begin
              push     = 1'b1;
              tok.data = SLIP_END;
            end else if (rx_byte == SLIP_ESC_ESC) begin
              push     = 1'b1;
              tok.data = SLIP_ESC;
            end else begin
              bad_next = 1'b1;
            end
          end else if (rx_byte == SLIP_ESC) begin
            esc_next = 1'b1;
          end else begin
            push = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame  <= 1'b0;
      esc       <= 1'b0;
      bad       <= 1'b0;
      raw_count <= '0;
    end else begin
      in_frame  <= in_frame_next;
      esc       <= esc_next;
      bad       <= bad_next;
      raw_count <= raw_count_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/sfr_queue.sv @@
`default_nettype none
module sfr_queue import sfr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire tok_t push_tok,
  input  wire logic pop,
  output tok_t      head,
  output logic      empty,
  output logic      full
);

  tok_t       slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/sfr_back.sv @@
`default_nettype none
module sfr_back import sfr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire tok_t       tok,
  input  wire logic       tok_valid,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            kind,
  output logic [7:0]      data_byte,
  output logic [7:0]      channel,
  output logic [2:0]      status,
  output logic            last
);

  logic [1:0]  dcnt, dcnt_next;
  logic [7:0]  chan, chan_next;
  logic [7:0]  hold0, hold0_next;
  logic [7:0]  hold1, hold1_next;
  logic [15:0] crc, crc_next;
  logic        pseen, pseen_next;

  logic        emit;
  logic        e_kind;
  logic [7:0]  e_data;
  logic [7:0]  e_chan;
  logic [2:0]  e_status;

  assign pop = tok_valid && (!out_valid || out_ready);

  always_comb begin
    dcnt_next  = dcnt;
    chan_next  = chan;
    hold0_next = hold0;
    hold1_next = hold1;
    crc_next   = crc;
    pseen_next = pseen;
    emit       = 1'b0;
    e_kind     = KIND_PAYLOAD;
    e_data     = hold0;
    e_chan     = chan;
    e_status   = ST_OK;
    if (pop) begin
      case (tok.kind)
        TOK_DATA: begin
          case (dcnt)
            2'd0: begin
              chan_next  = tok.data;
              hold0_next = tok.data;
              dcnt_next  = 2'd1;
            end
            2'd1: begin
              hold1_next = tok.data;
              dcnt_next  = 2'd2;
            end
            default: begin
              // release the oldest held byte, keep the last two as CRC candidates
              crc_next   = crc16_byte(crc, hold0);
              hold0_next = hold1;
              hold1_next = tok.data;
              if (dcnt == 2'd2) begin
                dcnt_next = 2'd3;
              end else begin
                pseen_next = 1'b1;
                emit       = 1'b1;
              end
            end
          endcase
        end
        TOK_CLOSE: begin
          emit   = 1'b1;
          e_kind = KIND_END;
          e_data = 8'h00;
          if (tok.err != ST_OK) begin
            e_status = tok.err;
          end else if (!pseen) begin
            e_status = ST_SHORT;
          end else if (crc != {hold0, hold1}) begin
            e_status = ST_CRC;
          end else begin
            e_status = ST_OK;
          end
          dcnt_next  = '0;
          chan_next  = '0;
          hold0_next = '0;
          hold1_next = '0;
          crc_next   = CRC_INIT;
          pseen_next = 1'b0;
        end
        TOK_ABORT: begin
          dcnt_next  = '0;
          chan_next  = '0;
          hold0_next = '0;
          hold1_next = '0;
          crc_next   = CRC_INIT;
          pseen_next = 1'b0;
        end
        default: begin
          dcnt_next = dcnt;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dcnt      <= '0;
      chan      <= '0;
      hold0     <= '0;
      hold1     <= '0;
      crc       <= CRC_INIT;
      pseen     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      dcnt  <= dcnt_next;
      chan  <= chan_next;
      hold0 <= hold0_next;
      hold1 <= hold1_next;
      crc   <= crc_next;
      pseen <= pseen_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind      <= e_kind;
      data_byte <= e_data;
      channel   <= e_chan;
      status    <= e_status;
      last      <= e_kind;
    end
  end

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import sfr_pkg::*;

  // One result word as it leaves the block, fields in port order.
  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic [7:0] chan;
    logic [2:0] st;
    logic       last;
  } slip_result_t;

  // One row of the directed table: a raw byte, plus a result typed in by hand
  // where it is obvious from the framing rules.
  typedef struct packed {
    logic [7:0]   b;
    logic         typed;
    slip_result_t w;
  } stim_row_t;

  localparam slip_result_t NO_WORD = '0;
  localparam int NUM_DIRECTED = 29;
  localparam int ITEM_TARGET  = 1950;
  localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
  localparam int STUCK_LIMIT  = 4000;   // cycles with no word moving
  localparam int DRAIN_CYCLES = 16;

  // Directed part: hunting, escapes, every status that can be read off by eye.
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{8'h00,    1'b0, NO_WORD},   // dropped while hunting
    '{SLIP_END, 1'b0, NO_WORD},   // opening delimiter
    '{8'hFF,    1'b0, NO_WORD},   // channel at its top value
    '{SLIP_ESC, 1'b0, NO_WORD},
    '{8'hDC,    1'b0, NO_WORD},   // escaped delimiter
    '{SLIP_ESC, 1'b0, NO_WORD},
    '{8'hDD,    1'b0, NO_WORD},   // escaped escape
    '{8'h00,    1'b1, '{KIND_PAYLOAD, 8'hC0, 8'hFF, ST_OK, 1'b0}},
    '{SLIP_END, 1'b0, NO_WORD},   // close, status from the CRC
    '{SLIP_END, 1'b0, NO_WORD},   // reopen
    '{8'h12,    1'b0, NO_WORD},
    '{SLIP_END, 1'b0, NO_WORD},   // too few raw bytes: silent, opens next frame
    '{8'h01,    1'b0, NO_WORD},
    '{8'h02,    1'b0, NO_WORD},
    '{8'h03,    1'b0, NO_WORD},
    '{SLIP_ESC, 1'b0, NO_WORD},   // escape left hanging at the close
    '{SLIP_END, 1'b1, '{KIND_END, 8'h00, 8'h01, ST_UNFINISHED, 1'b1}},
    '{SLIP_END, 1'b0, NO_WORD},
    '{8'h05,    1'b0, NO_WORD},
    '{SLIP_ESC, 1'b0, NO_WORD},
    '{8'h41,    1'b0, NO_WORD},   // bad escape, decoding stops
    '{8'h42,    1'b0, NO_WORD},   // only counted
    '{SLIP_END, 1'b1, '{KIND_END, 8'h00, 8'h05, ST_INVALID, 1'b1}},
    '{SLIP_END, 1'b0, NO_WORD},
    '{8'h07,    1'b0, NO_WORD},
    '{SLIP_ESC, 1'b0, NO_WORD},
    '{8'hDC,    1'b0, NO_WORD},
    '{8'h09,    1'b0, NO_WORD},   // four raw bytes but only three decoded
    '{SLIP_END, 1'b1, '{KIND_END, 8'h00, 8'h07, ST_SHORT, 1'b1}}
  };

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic       kind;
  logic [7:0] data_byte;
  logic [7:0] channel;
  logic [2:0] status;
  logic       last;

  // Travel alongside rx_byte so the monitor sees the row that was accepted.
  logic         row_typed;
  slip_result_t row_word;

  slip_frame_receiver_crc16 uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .data_byte (data_byte),
    .channel   (channel),
    .status    (status),
    .last      (last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Decoder/checker predictor state
  // ---------------------------------------------------------------------------
  bit          in_frame_q;
  bit          esc_pending_q;
  logic [2:0]  raw_cnt_q;       // saturates at MIN_RAW
  logic [1:0]  dec_cnt_q;       // saturates at 3
  logic [7:0]  chan_q;
  logic [7:0]  hold0_q;
  logic [7:0]  hold1_q;
  logic [15:0] crc_acc_q;
  logic [2:0]  err_q;
  bit          payload_seen_q;

  slip_result_t pending_frame_words[$];
  int           mismatches;
  int           result_count;
  int           stuck_cycles;

  // Shared between the sender and the receiver process.
  bit src_idle_en;
  bit snk_idle_en;
  bit hold_req;
  bit hold_done;

  logic [7:0] tx_bytes[$];

  // CRC-16/CCITT-FALSE, one bit at a time, MSB first.
  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  function automatic void clear_frame_state();
    esc_pending_q  = 1'b0;
    raw_cnt_q      = '0;
    dec_cnt_q      = '0;
    chan_q         = '0;
    hold0_q        = '0;
    hold1_q        = '0;
    crc_acc_q      = CRC_INIT;
    err_q          = ST_OK;
    payload_seen_q = 1'b0;
  endfunction

  // Advance the predictor by one raw byte; return 1 when a result word is due.
  function automatic bit slip_decode_step(input logic [7:0] b, output slip_result_t w);
    logic [7:0] d;
    bit         got;
    w   = NO_WORD;
    d   = '0;
    got = 1'b0;

    // Hunting: drop everything but an opening delimiter.
    if (!in_frame_q) begin
      if (b == SLIP_END) begin
        in_frame_q = 1'b1;
        clear_frame_state();
      end
      return 1'b0;
    end

    if (b == SLIP_END) begin
      // Too few raw bytes: forget the frame silently, stay in frame.
      if (raw_cnt_q < MIN_RAW) begin
        clear_frame_state();
        return 1'b0;
      end
      w.kind = KIND_END;
      w.chan = chan_q;
      w.last = 1'b1;
      if (err_q != ST_OK) begin
        w.st = err_q;
      end else if (esc_pending_q) begin
        w.st = ST_UNFINISHED;
      end else if (!payload_seen_q) begin
        w.st = ST_SHORT;
      end else if (crc_acc_q != {hold0_q, hold1_q}) begin
        w.st = ST_CRC;
      end else begin
        w.st = ST_OK;
      end
      clear_frame_state();
      in_frame_q = 1'b0;
      return 1'b1;
    end

    if (raw_cnt_q < MIN_RAW) begin
      raw_cnt_q = raw_cnt_q + 3'd1;
    end
    // After a bad escape, bytes are only counted.
    if (err_q != ST_OK) begin
      return 1'b0;
    end

    if (esc_pending_q) begin
      esc_pending_q = 1'b0;
      if (b == SLIP_ESC_END) begin
        d   = SLIP_END;
        got = 1'b1;
      end else if (b == SLIP_ESC_ESC) begin
        d   = SLIP_ESC;
        got = 1'b1;
      end else begin
        err_q = ST_INVALID;
      end
    end else if (b == SLIP_ESC) begin
      esc_pending_q = 1'b1;
    end else begin
      d   = b;
      got = 1'b1;
    end
    if (!got) begin
      return 1'b0;
    end

    // Two-byte delay line: the first decoded byte is the channel, the last two
    // of the frame are the CRC and never come out.
    case (dec_cnt_q)
      2'd0: begin
        chan_q    = d;
        hold0_q   = d;
        dec_cnt_q = 2'd1;
        return 1'b0;
      end
      2'd1: begin
        hold1_q   = d;
        dec_cnt_q = 2'd2;
        return 1'b0;
      end
      default: begin
        crc_acc_q = crc16_step(crc_acc_q, hold0_q);
        w.kind    = KIND_PAYLOAD;
        w.data    = hold0_q;
        w.chan    = chan_q;
        w.st      = ST_OK;
        w.last    = 1'b0;
        hold0_q   = hold1_q;
        hold1_q   = d;
        if (dec_cnt_q == 2'd2) begin
          // The channel byte goes into the CRC but is not a payload word.
          dec_cnt_q = 2'd3;
          return 1'b0;
        end
        payload_seen_q = 1'b1;
        return 1'b1;
      end
    endcase
  endfunction

  // Bias toward the framing codes so escapes come up often.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return SLIP_END;
      1:       return SLIP_ESC;
      2:       return SLIP_ESC_END;
      3:       return SLIP_ESC_ESC;
      4:       return 8'h00;
      5:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Frame builder: mostly well-formed frames with random content, the rest
  // bad CRC, bad escape, hanging escape, runt frames and line noise.
  // ---------------------------------------------------------------------------
  task automatic build_frame();
    logic [7:0]  body[$];
    logic [7:0]  bad;
    logic [15:0] crc;
    int          sel;
    int          len;
    int          pos;
    sel = $urandom_range(0, 99);

    if (sel >= 90) begin
      repeat ($urandom_range(1, 10)) tx_bytes.push_back(pick_byte());
      return;
    end
    if (sel >= 84) begin
      tx_bytes.push_back(SLIP_END);
      repeat ($urandom_range(1, 3)) tx_bytes.push_back(pick_byte());
      tx_bytes.push_back(SLIP_END);
      return;
    end

    // Keep most frames small; now and then a long one.
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
    body.push_back(pick_byte());
    repeat (len) body.push_back(pick_byte());
    crc = CRC_INIT;
    foreach (body[i]) begin
      crc = crc16_step(crc, body[i]);
    end
    if (sel >= 60 && sel < 70) begin
      crc = crc ^ 16'($urandom_range(1, 65535));
    end
    body.push_back(crc[15:8]);
    body.push_back(crc[7:0]);

    pos = $urandom_range(0, body.size() - 1);
    tx_bytes.push_back(SLIP_END);
    foreach (body[i]) begin
      if (sel >= 70 && sel < 78 && i == pos) begin
        bad = pick_byte();
        if (bad == SLIP_ESC_END || bad == SLIP_ESC_ESC) begin
          bad = 8'h5A;
        end
        tx_bytes.push_back(SLIP_ESC);
        tx_bytes.push_back(bad);
      end
      if (body[i] == SLIP_END) begin
        tx_bytes.push_back(SLIP_ESC);
        tx_bytes.push_back(SLIP_ESC_END);
      end else if (body[i] == SLIP_ESC) begin
        tx_bytes.push_back(SLIP_ESC);
        tx_bytes.push_back(SLIP_ESC_ESC);
      end else begin
        tx_bytes.push_back(body[i]);
      end
    end
    if (sel >= 78 && sel < 84) begin
      tx_bytes.push_back(SLIP_ESC);
    end
    tx_bytes.push_back(SLIP_END);
  endtask

  // Offer one word, maybe after an idle burst; return at the accepting edge.
  task automatic send_word(input logic [7:0] b, input logic typed, input slip_result_t w);
    if (src_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    rx_byte   <= b;
    row_typed <= typed;
    row_word  <= w;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted input word, check every accepted result
  // word against the oldest prediction, and track how long nothing has moved.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    bit           moved;
    bit           due;
    slip_result_t predicted;
    slip_result_t seen;
    slip_result_t want;
    if (!rst) begin
      moved = 1'b0;
      if (in_valid && in_ready === 1'b1) begin
        moved = 1'b1;
        due   = slip_decode_step(rx_byte, predicted);
        // Hand-typed rows take the place of the predicted word.
        if (row_typed) begin
          pending_frame_words.push_back(row_word);
        end else if (due) begin
          pending_frame_words.push_back(predicted);
        end
      end
      if (out_valid === 1'b1 && out_ready) begin
        moved = 1'b1;
        seen  = {kind, data_byte, channel, status, last};
        if (pending_frame_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result word %0d: kind=%0d data=%02h ch=%02h st=%0d last=%0d",
                     $time, result_count, seen.kind, seen.data, seen.chan, seen.st, seen.last);
          end
        end else begin
          want = pending_frame_words.pop_front();
          if (seen.kind !== want.kind || seen.data !== want.data ||
              seen.chan !== want.chan || seen.st !== want.st || seen.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result word %0d mismatch", $time, result_count);
              $display("  expected kind=%0d data=%02h ch=%02h st=%0d last=%0d",
                       want.kind, want.data, want.chan, want.st, want.last);
              $display("  actual   kind=%0d data=%02h ch=%02h st=%0d last=%0d",
                       seen.kind, seen.data, seen.chan, seen.st, seen.last);
            end
          end
        end
        result_count++;
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
    end
  end

  // Kill the run if no word moves on either side for too long.
  initial begin : watchdog
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("FAIL slip_frame_receiver_crc16");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: random ready with idle bursts, plus one long hold-off on
  // request so the block fills up and stalls its input.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (snk_idle_en && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Byte source: directed table first, then random frames until the target
  // word count is reached, then drain and report.
  // ---------------------------------------------------------------------------
  initial begin : byte_source
    int fed_words;
    bit paused;
    rst         = 1'b1;
    in_valid    = 1'b0;
    rx_byte     = '0;
    row_typed   = 1'b0;
    row_word    = NO_WORD;
    src_idle_en = 1'b1;
    snk_idle_en = 1'b1;
    hold_req    = 1'b0;
    hold_done   = 1'b0;
    mismatches  = 0;
    result_count = 0;
    stuck_cycles = 0;
    fed_words   = 0;
    paused      = 1'b0;
    in_frame_q  = 1'b0;
    clear_frame_state();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_ROWS[i]) begin
      send_word(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].w);
    end
    fed_words = NUM_DIRECTED;

    while (fed_words < ITEM_TARGET) begin
      // Line noise between frames; the block is usually hunting here, so
      // these do not count toward the total.
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(0, 191)), 1'b0, NO_WORD);
      end
      build_frame();
      fed_words += tx_bytes.size();
      while (tx_bytes.size() != 0) begin
        send_word(tx_bytes.pop_front(), 1'b0, NO_WORD);
      end

      // Stall the result side for a long stretch while bytes keep coming.
      if (!hold_req && fed_words >= 700) begin
        hold_req = 1'b1;
      end
      // Hold the input until every predicted word has come out.
      if (!paused && fed_words >= 1200) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_frame_words.size() != 0);
      end
      // Full rate at the end; elsewhere flip idling on and off now and then.
      if (fed_words >= ITEM_TARGET - 200) begin
        src_idle_en = 1'b0;
        snk_idle_en = 1'b0;
      end else begin
        if ($urandom_range(0, 7) == 0) src_idle_en = !src_idle_en;
        if ($urandom_range(0, 7) == 0) snk_idle_en = !snk_idle_en;
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending_frame_words.size() != 0);
    // Give a stray extra word time to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_frame_words.size() == 0) begin
      $display("PASS slip_frame_receiver_crc16");
    end else begin
      $display("FAIL slip_frame_receiver_crc16");
    end
    $finish;
  end

endmodule

@@ slip_frame_receiver_crc16.f @@
+incdir+rtl/core
rtl/core/sfr_pkg.sv
rtl/core/sfr_front.sv
rtl/core/sfr_queue.sv
rtl/core/sfr_back.sv
rtl/core/slip_frame_receiver_crc16.sv
tb/testbench.sv
